// File: rtl/ppaf_pkg.sv
package ppaf_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ANGLE_W         = 15;

    // reduced vector components: magnitude below 2^15, sign kept
    localparam int MAG_W   = 15;
    localparam int RED_W   = MAG_W + 1;
    localparam int VM_W    = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * RED_W;
    localparam int CROSS_W = PROD_W + 1;

    // cosine / sine datapath
    localparam int NORM_ROOT_W = RED_W;
    localparam int NSQ_W       = 2 * NORM_ROOT_W;
    localparam int DOT_W       = NSQ_W + 1;
    localparam int DIV_W       = NSQ_W;
    localparam int Q_W         = 31;
    localparam int SIN_ROOT_W  = Q_W;
    localparam int SIN_RAD_W   = 2 * SIN_ROOT_W;

    // CORDIC, degrees in Q16
    localparam int CORDIC_N = 20;
    localparam int XY_W     = Q_W + 2;
    localparam int Z_W      = 26;
    localparam int ZC_W     = 24;
    localparam int DEG_HALF = 180;
    localparam int DEG_QTR  = 90;
    localparam int DEG_FRAC = 16;

    // registered stages of one angle unit
    localparam int ANGLE_LAT = 2 + NORM_ROOT_W + 2 + Q_W + 3 + SIN_ROOT_W + 1 + CORDIC_N + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_pos_x;
        logic signed [COORD_WIDTH-1:0] first_pos_y;
        logic signed [COORD_WIDTH-1:0] first_pos_z;
        logic signed [COORD_WIDTH-1:0] first_dir_x;
        logic signed [COORD_WIDTH-1:0] first_dir_y;
        logic signed [COORD_WIDTH-1:0] first_dir_z;
        logic signed [COORD_WIDTH-1:0] second_pos_x;
        logic signed [COORD_WIDTH-1:0] second_pos_y;
        logic signed [COORD_WIDTH-1:0] second_pos_z;
        logic signed [COORD_WIDTH-1:0] second_dir_x;
        logic signed [COORD_WIDTH-1:0] second_dir_y;
        logic signed [COORD_WIDTH-1:0] second_dir_z;
    } in_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_first;
        logic [ANGLE_W-1:0] angle_second;
        logic [ANGLE_W-1:0] angle_normals;
        logic               degenerate;
    } out_word_t;

    // atan(2^-i) in degrees, Q16, rounded
    function automatic logic [21:0] atan_q16(input int idx);
        logic [21:0] r;
        case (idx)
            0:       r = 22'd2949120;
            1:       r = 22'd1740967;
            2:       r = 22'd919879;
            3:       r = 22'd466945;
            4:       r = 22'd234379;
            5:       r = 22'd117304;
            6:       r = 22'd58666;
            7:       r = 22'd29335;
            8:       r = 22'd14668;
            9:       r = 22'd7334;
            10:      r = 22'd3667;
            11:      r = 22'd1833;
            12:      r = 22'd917;
            13:      r = 22'd458;
            14:      r = 22'd229;
            15:      r = 22'd115;
            16:      r = 22'd57;
            17:      r = 22'd29;
            18:      r = 22'd14;
            19:      r = 22'd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ppaf_reduce.sv
module ppaf_reduce #(
    parameter int W = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [W-1:0]               v [3],
    output logic signed [ppaf_pkg::RED_W-1:0] r [3],
    output logic                              zero
);
    import ppaf_pkg::*;

    localparam int KW = $clog2(W);

    logic [W-1:0]            mag_c [3];
    logic [W-1:0]            ormag_c;
    logic [KW-1:0]           msb_c;
    logic [KW-1:0]           k_c;
    logic [W-1:0]            mag_reg [3];
    logic [2:0]              neg_reg;
    logic [KW-1:0]           k_reg;
    logic                    zero_a_reg;
    logic [W-1:0]            sh_c [3];
    logic signed [RED_W-1:0] r_next [3];
    logic signed [RED_W-1:0] r_reg [3];
    logic                    zero_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_c[i] = v[i][W-1] ? W'(-v[i]) : W'(v[i]);
        end
        ormag_c = mag_c[0] | mag_c[1] | mag_c[2];
        msb_c = '0;
        for (int j = 0; j < W; j++)
        begin
            if (ormag_c[j])
            begin
                msb_c = KW'(j);
            end
        end
        k_c = (msb_c > KW'(MAG_W - 1)) ? KW'(msb_c - KW'(MAG_W - 1)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_c[i];
                neg_reg[i] <= v[i][W-1];
            end
            k_reg      <= k_c;
            zero_a_reg <= (ormag_c == '0);
        end
    end

    // magnitude shifted, sign put back: rounds toward zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh_c[i] = mag_reg[i] >> k_reg;
            r_next[i] = neg_reg[i] ? -signed'({1'b0, sh_c[i][MAG_W-1:0]})
                                   : signed'({1'b0, sh_c[i][MAG_W-1:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            zero_reg <= zero_a_reg;
        end
    end

    assign r    = r_reg;
    assign zero = zero_reg;

endmodule

// File: rtl/ppaf_sqrt_cell.sv
module ppaf_sqrt_cell #(
    parameter int ROOT_W = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ROOT_W:0]       rem_in,
    input  logic [ROOT_W-1:0]     root_in,
    input  logic [2*ROOT_W-1:0]   rad_in,
    output logic [ROOT_W:0]       rem_out,
    output logic [ROOT_W-1:0]     root_out,
    output logic [2*ROOT_W-1:0]   rad_out
);

    logic [ROOT_W+2:0]   rs_c;
    logic [ROOT_W+2:0]   tr_c;
    logic [ROOT_W+2:0]   diff_c;
    logic                ge_c;
    logic [ROOT_W:0]     rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [2*ROOT_W-1:0] rad_reg;

    // one root digit: bring down two radicand bits, try 4r+1
    always_comb
    begin
        rs_c      = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
        tr_c      = {1'b0, root_in, 2'b01};
        ge_c      = (rs_c >= tr_c);
        diff_c    = rs_c - tr_c;
        rem_next  = ge_c ? diff_c[ROOT_W:0] : rs_c[ROOT_W:0];
        root_next = {root_in[ROOT_W-2:0], ge_c};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_in[2*ROOT_W-3:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

// File: rtl/ppaf_div_cell.sv
module ppaf_div_cell #(
    parameter int P_W = 32,
    parameter int QB  = 31
) (
    input  logic           clk,
    input  logic           en,
    input  logic [P_W-1:0] rem_in,
    input  logic [P_W-1:0] div_in,
    input  logic [QB-1:0]  quo_in,
    input  logic           bit_in,
    output logic [P_W-1:0] rem_out,
    output logic [P_W-1:0] div_out,
    output logic [QB-1:0]  quo_out
);

    logic [P_W:0]   rs_c;
    logic [P_W:0]   diff_c;
    logic           ge_c;
    logic [P_W-1:0] rem_next;
    logic [P_W-1:0] rem_reg;
    logic [P_W-1:0] div_reg;
    logic [QB-1:0]  quo_reg;

    always_comb
    begin
        rs_c     = {rem_in, bit_in};
        ge_c     = (rs_c >= {1'b0, div_in});
        diff_c   = rs_c - {1'b0, div_in};
        rem_next = ge_c ? diff_c[P_W-1:0] : rs_c[P_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            div_reg <= div_in;
            quo_reg <= {quo_in[QB-2:0], ge_c};
        end
    end

    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign quo_out = quo_reg;

endmodule

// File: rtl/ppaf_cordic_cell.sv
module ppaf_cordic_cell #(
    parameter int IDX  = 0,
    parameter int XY_W = 33,
    parameter int Z_W  = 26
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out
);
    import ppaf_pkg::*;

    localparam logic signed [Z_W-1:0] STEP = Z_W'(atan_q16(IDX));

    logic signed [XY_W-1:0] dx_c;
    logic signed [XY_W-1:0] dy_c;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    always_comb
    begin
        dx_c = y_in >>> IDX;
        dy_c = x_in >>> IDX;
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (y_in > 0)
        begin
            x_next = x_in + dx_c;
            y_next = y_in - dy_c;
            z_next = z_in + STEP;
        end
        else if (y_in < 0)
        begin
            x_next = x_in - dx_c;
            y_next = y_in + dy_c;
            z_next = z_in - STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: rtl/ppaf_angle.sv
module ppaf_angle #(
    parameter int FRAC_BITS = ppaf_pkg::ANGLE_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [ppaf_pkg::RED_W-1:0]   a [3],
    input  logic signed [ppaf_pkg::RED_W-1:0]   b [3],
    output logic [ppaf_pkg::ANGLE_W-1:0]        angle
);
    import ppaf_pkg::*;

    localparam int SH = DEG_FRAC - FRAC_BITS;
    localparam logic [Q_W-1:0]       COS_ONE = Q_W'(1) << (Q_W - 1);
    localparam logic [SIN_RAD_W-1:0] RAD_ONE = SIN_RAD_W'(1) << (2 * (Q_W - 1));
    localparam logic [ZC_W-1:0]      Z_MAX   = ZC_W'(DEG_HALF) << DEG_FRAC;
    localparam logic signed [Z_W-1:0] Z_QTR  = Z_W'(DEG_QTR) << DEG_FRAC;

    // products and sums
    logic signed [PROD_W-1:0] pd_reg [3];
    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    logic signed [DOT_W-1:0]  dot_c;
    logic [DOT_W-1:0]         dabs_c;
    logic [NSQ_W-1:0]         dmag_reg;
    logic                     dneg_reg;
    logic [NSQ_W-1:0]         n2a_reg;
    logic [NSQ_W-1:0]         n2b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= a[i] * b[i];
                pa_reg[i] <= a[i] * a[i];
                pb_reg[i] <= b[i] * b[i];
            end
        end
    end

    always_comb
    begin
        dot_c  = DOT_W'(pd_reg[0]) + DOT_W'(pd_reg[1]) + DOT_W'(pd_reg[2]);
        dabs_c = dot_c[DOT_W-1] ? DOT_W'(-dot_c) : DOT_W'(dot_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg <= dabs_c[NSQ_W-1:0];
            dneg_reg <= dot_c[DOT_W-1];
            n2a_reg  <= $unsigned(pa_reg[0]) + $unsigned(pa_reg[1]) + $unsigned(pa_reg[2]);
            n2b_reg  <= $unsigned(pb_reg[0]) + $unsigned(pb_reg[1]) + $unsigned(pb_reg[2]);
        end
    end

    // norm roots, two chains side by side
    logic [NORM_ROOT_W:0]   sa_rem  [NORM_ROOT_W+1];
    logic [NORM_ROOT_W-1:0] sa_root [NORM_ROOT_W+1];
    logic [NSQ_W-1:0]       sa_rad  [NORM_ROOT_W+1];
    logic [NORM_ROOT_W:0]   sb_rem  [NORM_ROOT_W+1];
    logic [NORM_ROOT_W-1:0] sb_root [NORM_ROOT_W+1];
    logic [NSQ_W-1:0]       sb_rad  [NORM_ROOT_W+1];
    logic [NSQ_W-1:0]       dm_dly_reg [NORM_ROOT_W];
    logic [NORM_ROOT_W-1:0] dn_dly_reg;

    assign sa_rem[0]  = '0;
    assign sa_root[0] = '0;
    assign sa_rad[0]  = n2a_reg;
    assign sb_rem[0]  = '0;
    assign sb_root[0] = '0;
    assign sb_rad[0]  = n2b_reg;

    for (genvar j = 0; j < NORM_ROOT_W; j++)
    begin : g_norm
        ppaf_sqrt_cell #(.ROOT_W(NORM_ROOT_W)) u_sa (
            .clk      (clk),
            .en       (en),
            .rem_in   (sa_rem[j]),
            .root_in  (sa_root[j]),
            .rad_in   (sa_rad[j]),
            .rem_out  (sa_rem[j+1]),
            .root_out (sa_root[j+1]),
            .rad_out  (sa_rad[j+1])
        );
        ppaf_sqrt_cell #(.ROOT_W(NORM_ROOT_W)) u_sb (
            .clk      (clk),
            .en       (en),
            .rem_in   (sb_rem[j]),
            .root_in  (sb_root[j]),
            .rad_in   (sb_rad[j]),
            .rem_out  (sb_rem[j+1]),
            .root_out (sb_root[j+1]),
            .rad_out  (sb_rad[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_dly_reg[0] <= dmag_reg;
            for (int j = 1; j < NORM_ROOT_W; j++)
            begin
                dm_dly_reg[j] <= dm_dly_reg[j-1];
            end
            dn_dly_reg <= {dn_dly_reg[NORM_ROOT_W-2:0], dneg_reg};
        end
    end

    // divisor and overflow test
    logic [DIV_W-1:0] prod_reg;
    logic [NSQ_W-1:0] dm3_reg;
    logic             neg3_reg;
    logic [DIV_W-1:0] p4_reg;
    logic [DIV_W-1:0] rem4_reg;
    logic             bit4_reg;
    logic             ovf4_reg;
    logic             neg4_reg;
    logic             ovf_c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= sa_root[NORM_ROOT_W] * sb_root[NORM_ROOT_W];
            dm3_reg  <= dm_dly_reg[NORM_ROOT_W-1];
            neg3_reg <= dn_dly_reg[NORM_ROOT_W-1];
        end
    end

    // quotient reaches 2^31 exactly when |d| >= 2*prod
    assign ovf_c = ({1'b0, dm3_reg} >= {prod_reg, 1'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg   <= prod_reg;
            rem4_reg <= ovf_c ? '0 : {1'b0, dm3_reg[NSQ_W-1:1]};
            bit4_reg <= dm3_reg[0];
            ovf4_reg <= ovf_c;
            neg4_reg <= neg3_reg;
        end
    end

    // restoring divider, one quotient bit per cell
    logic [DIV_W-1:0] dv_rem [Q_W+1];
    logic [DIV_W-1:0] dv_div [Q_W+1];
    logic [Q_W-1:0]   dv_quo [Q_W+1];
    logic [Q_W-1:0]   dov_dly_reg;
    logic [Q_W-1:0]   dng_dly_reg;

    assign dv_rem[0] = rem4_reg;
    assign dv_div[0] = p4_reg;
    assign dv_quo[0] = '0;

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        ppaf_div_cell #(.P_W(DIV_W), .QB(Q_W)) u_dc (
            .clk     (clk),
            .en      (en),
            .rem_in  (dv_rem[j]),
            .div_in  (dv_div[j]),
            .quo_in  (dv_quo[j]),
            .bit_in  ((j == 0) ? bit4_reg : 1'b0),
            .rem_out (dv_rem[j+1]),
            .div_out (dv_div[j+1]),
            .quo_out (dv_quo[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dov_dly_reg <= {dov_dly_reg[Q_W-2:0], ovf4_reg};
            dng_dly_reg <= {dng_dly_reg[Q_W-2:0], neg4_reg};
        end
    end

    // cosine magnitude, square, sine radicand
    logic [Q_W-1:0]       cm5_reg;
    logic                 neg5_reg;
    logic [SIN_RAD_W-1:0] sq6_reg;
    logic [Q_W-1:0]       cm6_reg;
    logic                 neg6_reg;
    logic [SIN_RAD_W-1:0] rad7_reg;
    logic [Q_W-1:0]       cm7_reg;
    logic                 neg7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm5_reg  <= (dov_dly_reg[Q_W-1] || (dv_quo[Q_W] > COS_ONE)) ? COS_ONE
                                                                        : dv_quo[Q_W];
            neg5_reg <= dng_dly_reg[Q_W-1];
            sq6_reg  <= cm5_reg * cm5_reg;
            cm6_reg  <= cm5_reg;
            neg6_reg <= neg5_reg;
            rad7_reg <= RAD_ONE - sq6_reg;
            cm7_reg  <= cm6_reg;
            neg7_reg <= neg6_reg;
        end
    end

    // sine root
    logic [SIN_ROOT_W:0]   ss_rem  [SIN_ROOT_W+1];
    logic [SIN_ROOT_W-1:0] ss_root [SIN_ROOT_W+1];
    logic [SIN_RAD_W-1:0]  ss_rad  [SIN_ROOT_W+1];
    logic [Q_W-1:0]        cm_dly_reg [SIN_ROOT_W];
    logic [SIN_ROOT_W-1:0] cn_dly_reg;

    assign ss_rem[0]  = '0;
    assign ss_root[0] = '0;
    assign ss_rad[0]  = rad7_reg;

    for (genvar j = 0; j < SIN_ROOT_W; j++)
    begin : g_sin
        ppaf_sqrt_cell #(.ROOT_W(SIN_ROOT_W)) u_ss (
            .clk      (clk),
            .en       (en),
            .rem_in   (ss_rem[j]),
            .root_in  (ss_root[j]),
            .rad_in   (ss_rad[j]),
            .rem_out  (ss_rem[j+1]),
            .root_out (ss_root[j+1]),
            .rad_out  (ss_rad[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_dly_reg[0] <= cm7_reg;
            for (int j = 1; j < SIN_ROOT_W; j++)
            begin
                cm_dly_reg[j] <= cm_dly_reg[j-1];
            end
            cn_dly_reg <= {cn_dly_reg[SIN_ROOT_W-2:0], neg7_reg};
        end
    end

    // negative cosine: turn by -90 degrees first
    logic signed [XY_W-1:0] cx [CORDIC_N+1];
    logic signed [XY_W-1:0] cy [CORDIC_N+1];
    logic signed [Z_W-1:0]  cz [CORDIC_N+1];
    logic signed [XY_W-1:0] x8_reg;
    logic signed [XY_W-1:0] y8_reg;
    logic signed [Z_W-1:0]  z8_reg;
    logic [Q_W-1:0]         cm8_c;
    logic                   turn_c;

    always_comb
    begin
        cm8_c  = cm_dly_reg[SIN_ROOT_W-1];
        turn_c = cn_dly_reg[SIN_ROOT_W-1] && (cm8_c != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (turn_c)
            begin
                x8_reg <= signed'(XY_W'(ss_root[SIN_ROOT_W]));
                y8_reg <= signed'(XY_W'(cm8_c));
                z8_reg <= Z_QTR;
            end
            else
            begin
                x8_reg <= signed'(XY_W'(cm8_c));
                y8_reg <= signed'(XY_W'(ss_root[SIN_ROOT_W]));
                z8_reg <= '0;
            end
        end
    end

    assign cx[0] = x8_reg;
    assign cy[0] = y8_reg;
    assign cz[0] = z8_reg;

    for (genvar j = 0; j < CORDIC_N; j++)
    begin : g_cordic
        ppaf_cordic_cell #(.IDX(j), .XY_W(XY_W), .Z_W(Z_W)) u_cc (
            .clk   (clk),
            .en    (en),
            .x_in  (cx[j]),
            .y_in  (cy[j]),
            .z_in  (cz[j]),
            .x_out (cx[j+1]),
            .y_out (cy[j+1]),
            .z_out (cz[j+1])
        );
    end

    // clamp to [0, 180] and round half up
    logic [ZC_W-1:0]    zc_c;
    logic [ANGLE_W-1:0] angle_next;
    logic [ANGLE_W-1:0] angle_reg;

    always_comb
    begin
        if (cz[CORDIC_N] < 0)
        begin
            zc_c = '0;
        end
        else if (cz[CORDIC_N] > signed'(Z_W'(Z_MAX)))
        begin
            zc_c = Z_MAX;
        end
        else
        begin
            zc_c = cz[CORDIC_N][ZC_W-1:0];
        end
    end

    if (SH == 0)
    begin : g_no_round
        assign angle_next = zc_c[ANGLE_W-1:0];
    end
    else
    begin : g_round
        logic [31:0] rsum;
        assign rsum       = 32'(zc_c) + (32'd1 << (SH - 1));
        assign angle_next = rsum[SH +: ANGLE_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// File: rtl/point_pair_angle_feature_core.sv
// Point pair feature angles, fully pipelined.
// Throughput: one pair per cycle unless out_ready stalls the chain; every stage
// is a register in a fixed chain of cells (two norm roots, 31-step divider,
// 31-step sine root, 20 CORDIC steps).
// out_ready low freezes the whole chain while a result is held.
// rst_n (asynchronous, active low) clears the valid flags only.
module point_pair_angle_feature_core #(
    parameter int ANGLE_FRAC_BITS = ppaf_pkg::ANGLE_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppaf_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ppaf_pkg::out_word_t out_data
);
    import ppaf_pkg::*;

    localparam int FRONT_LAT = 7;
    localparam int PIPE_LAT  = FRONT_LAT + ANGLE_LAT + 1;

    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;

    assign en        = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    // input word and difference vector
    logic signed [COORD_WIDTH-1:0] v1_reg [3];
    logic signed [COORD_WIDTH-1:0] v2_reg [3];
    logic signed [VM_W-1:0]        vm_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg[0] <= in_data.first_dir_x;
            v1_reg[1] <= in_data.first_dir_y;
            v1_reg[2] <= in_data.first_dir_z;
            v2_reg[0] <= in_data.second_dir_x;
            v2_reg[1] <= in_data.second_dir_y;
            v2_reg[2] <= in_data.second_dir_z;
            vm_reg[0] <= VM_W'(in_data.second_pos_x) - VM_W'(in_data.first_pos_x);
            vm_reg[1] <= VM_W'(in_data.second_pos_y) - VM_W'(in_data.first_pos_y);
            vm_reg[2] <= VM_W'(in_data.second_pos_z) - VM_W'(in_data.first_pos_z);
        end
    end

    logic signed [RED_W-1:0] v1r [3];
    logic signed [RED_W-1:0] v2r [3];
    logic signed [RED_W-1:0] vmr [3];
    logic                    z1;
    logic                    z2;
    logic                    zm;

    ppaf_reduce #(.W(COORD_WIDTH)) u_red_v1 (
        .clk (clk), .en (en), .v (v1_reg), .r (v1r), .zero (z1)
    );
    ppaf_reduce #(.W(COORD_WIDTH)) u_red_v2 (
        .clk (clk), .en (en), .v (v2_reg), .r (v2r), .zero (z2)
    );
    ppaf_reduce #(.W(VM_W)) u_red_vm (
        .clk (clk), .en (en), .v (vm_reg), .r (vmr), .zero (zm)
    );

    // normals: products, then differences
    logic signed [PROD_W-1:0]  pna_reg [6];
    logic signed [PROD_W-1:0]  pnb_reg [6];
    logic signed [CROSS_W-1:0] na_reg [3];
    logic signed [CROSS_W-1:0] nb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pna_reg[0] <= v1r[1] * vmr[2];
            pna_reg[1] <= v1r[2] * vmr[1];
            pna_reg[2] <= v1r[2] * vmr[0];
            pna_reg[3] <= v1r[0] * vmr[2];
            pna_reg[4] <= v1r[0] * vmr[1];
            pna_reg[5] <= v1r[1] * vmr[0];
            pnb_reg[0] <= v2r[1] * vmr[2];
            pnb_reg[1] <= v2r[2] * vmr[1];
            pnb_reg[2] <= v2r[2] * vmr[0];
            pnb_reg[3] <= v2r[0] * vmr[2];
            pnb_reg[4] <= v2r[0] * vmr[1];
            pnb_reg[5] <= v2r[1] * vmr[0];
            for (int i = 0; i < 3; i++)
            begin
                na_reg[i] <= CROSS_W'(pna_reg[2*i]) - CROSS_W'(pna_reg[2*i+1]);
                nb_reg[i] <= CROSS_W'(pnb_reg[2*i]) - CROSS_W'(pnb_reg[2*i+1]);
            end
        end
    end

    logic signed [RED_W-1:0] nar [3];
    logic signed [RED_W-1:0] nbr [3];
    logic                    zna;
    logic                    znb;

    ppaf_reduce #(.W(CROSS_W)) u_red_na (
        .clk (clk), .en (en), .v (na_reg), .r (nar), .zero (zna)
    );
    ppaf_reduce #(.W(CROSS_W)) u_red_nb (
        .clk (clk), .en (en), .v (nb_reg), .r (nbr), .zero (znb)
    );

    // keep reduced inputs in step with the normals
    logic signed [RED_W-1:0] v1d_reg [4][3];
    logic signed [RED_W-1:0] v2d_reg [4][3];
    logic signed [RED_W-1:0] vmd_reg [4][3];
    logic [2:0]              zd_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1d_reg[0] <= v1r;
            v2d_reg[0] <= v2r;
            vmd_reg[0] <= vmr;
            zd_reg[0]  <= {z1, z2, zm};
            for (int s = 1; s < 4; s++)
            begin
                v1d_reg[s] <= v1d_reg[s-1];
                v2d_reg[s] <= v2d_reg[s-1];
                vmd_reg[s] <= vmd_reg[s-1];
                zd_reg[s]  <= zd_reg[s-1];
            end
        end
    end

    logic [ANGLE_W-1:0] ang_first;
    logic [ANGLE_W-1:0] ang_second;
    logic [ANGLE_W-1:0] ang_normals;

    ppaf_angle #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_first (
        .clk (clk), .en (en), .a (v1d_reg[3]), .b (vmd_reg[3]), .angle (ang_first)
    );
    ppaf_angle #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_second (
        .clk (clk), .en (en), .a (v2d_reg[3]), .b (vmd_reg[3]), .angle (ang_second)
    );
    ppaf_angle #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_normals (
        .clk (clk), .en (en), .a (nar), .b (nbr), .angle (ang_normals)
    );

    logic [ANGLE_LAT-1:0] deg_dly_reg;
    logic                 deg_c;
    out_word_t            out_reg;

    assign deg_c = (|zd_reg[3]) | zna | znb;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_dly_reg <= {deg_dly_reg[ANGLE_LAT-2:0], deg_c};
            out_reg.degenerate    <= deg_dly_reg[ANGLE_LAT-1];
            out_reg.angle_first   <= deg_dly_reg[ANGLE_LAT-1] ? '0 : ang_first;
            out_reg.angle_second  <= deg_dly_reg[ANGLE_LAT-1] ? '0 : ang_second;
            out_reg.angle_normals <= deg_dly_reg[ANGLE_LAT-1] ? '0 : ang_normals;
        end
    end

    assign out_data = out_reg;

`ifndef ASSERT_OFF
    // a zero-length vector forces all angles to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.angle_first == '0 && out_data.angle_second == '0 &&
            out_data.angle_normals == '0)
        else $error("degenerate word with nonzero angle");

    // the input side only stalls behind a held result word
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a held word");

    // a taken word is replaced by the next stage, not repeated
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !vld_reg[PIPE_LAT-2] |=> !out_valid)
        else $error("result word repeated");
`endif

endmodule
